>>> hdl/ball_wall_and_pair_collision_defines.svh
// Assertion macros for the ball wall and pair collision block.
// Used by the port checker; needs i_clk and i_rst_n in scope.
`ifndef BALL_WALL_AND_PAIR_COLLISION_DEFINES_SVH
`define BALL_WALL_AND_PAIR_COLLISION_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BWPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bwpc check failed");

// next-cycle implication, disabled during reset
`define BWPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bwpc check failed");

`endif

>>> hdl/bwpc_pkg.sv
// Package for the ball wall and pair collision block: widths, codes,
// payload and pipeline types, saturation helpers. No dependencies.
package bwpc_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRAC_BITS     = 13;
    localparam int RAD_BITS      = 14;
    localparam int HALF_BITS     = 15;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;

    localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(16384);

    localparam logic REG_HALF_WIDTH  = 1'b0;
    localparam logic REG_HALF_HEIGHT = 1'b1;
    localparam logic OP_ADVANCE      = 1'b0;
    localparam logic OP_PAIR         = 1'b1;

    // derived datapath widths
    localparam int D_W     = COORD_BITS + 1;
    localparam int D2_W    = 2 * D_W;
    localparam int P_W     = 2 * D_W + 1;
    localparam int P_LO_W  = (P_W + 1) / 2;
    localparam int P_HI_W  = P_W - P_LO_W;
    localparam int GUARD   = FRAC_BITS + 1;
    localparam int SQ_IN_W = D2_W + 2 * GUARD;
    localparam int ROOT_W  = SQ_IN_W / 2;
    localparam int NUMV_W  = D_W + P_W;
    localparam int MAGV_W  = NUMV_W + 1;
    localparam int RS_W    = RAD_BITS + 1;
    localparam int DR_W    = D_W + RS_W + 1;
    localparam int MAGP_W  = DR_W + GUARD + 1;
    localparam int Q_W     = COORD_BITS + 2;
    localparam int SAT_W   = COORD_BITS + 4;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic                operation;
        t_coord              a_x;
        t_coord              a_y;
        t_coord              a_vx;
        t_coord              a_vy;
        logic [RAD_BITS-1:0] a_radius;
        t_coord              b_x;
        t_coord              b_y;
        t_coord              b_vx;
        t_coord              b_vy;
        logic [RAD_BITS-1:0] b_radius;
    } t_in;

    typedef struct packed {
        t_coord new_a_x;
        t_coord new_a_y;
        t_coord new_a_vx;
        t_coord new_a_vy;
        t_coord new_b_x;
        t_coord new_b_y;
        t_coord new_b_vx;
        t_coord new_b_vy;
        logic   hit;
    } t_out;

    // fields carried down the whole pipe
    typedef struct packed {
        logic                 op;
        t_coord               a_x;
        t_coord               a_y;
        t_coord               a_vx;
        t_coord               a_vy;
        t_coord               b_x;
        t_coord               b_y;
        t_coord               b_vx;
        t_coord               b_vy;
        t_coord               w_x;
        t_coord               w_y;
        t_coord               w_vx;
        t_coord               w_vy;
        logic                 w_hit;
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
    } t_side;

    typedef struct packed {
        t_side                 side;
        logic signed [D_W-1:0] dvx;
        logic signed [D_W-1:0] dvy;
        logic [RS_W-1:0]       rs;
    } t_s1;

    typedef struct packed {
        t_side                      side;
        logic [D2_W-1:0]            dx2;
        logic [D2_W-1:0]            dy2;
        logic signed [2*D_W-1:0]    px;
        logic signed [2*D_W-1:0]    py;
        logic [2*RS_W-1:0]          rs2;
        logic signed [DR_W-1:0]     dxr;
        logic signed [DR_W-1:0]     dyr;
    } t_s2;

    typedef struct packed {
        t_side                  side;
        logic [D2_W-1:0]        d2;
        logic signed [P_W-1:0]  p;
        logic                   close;
        logic signed [DR_W-1:0] dxr;
        logic signed [DR_W-1:0] dyr;
    } t_sq;

    typedef struct packed {
        t_sq                               sq;
        logic [ROOT_W-1:0]                 len;
        logic signed [D_W+P_LO_W:0]        lox;
        logic signed [D_W+P_HI_W-1:0]      hix;
        logic signed [D_W+P_LO_W:0]        loy;
        logic signed [D_W+P_HI_W-1:0]      hiy;
    } t_pa;

    typedef struct packed {
        t_sq                      sq;
        logic [ROOT_W-1:0]        len;
        logic signed [NUMV_W-1:0] numx;
        logic signed [NUMV_W-1:0] numy;
    } t_pb;

    typedef struct packed {
        t_side             side;
        logic              close;
        logic [D2_W-1:0]   d2;
        logic [ROOT_W-1:0] len;
        logic [MAGV_W-1:0] magvx;
        logic [MAGV_W-1:0] magvy;
        logic [MAGP_W-1:0] magpx;
        logic [MAGP_W-1:0] magpy;
        logic              negvx;
        logic              negvy;
        logic              negpx;
        logic              negpy;
    } t_pc;

    typedef struct packed {
        t_side side;
        logic  close;
        logic  neg;
    } t_fin;

    localparam int SQ_SB_W  = $bits(t_sq);
    localparam int FIN_SB_W = $bits(t_fin);

    function automatic t_coord sat_coord(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = signed'({{(SAT_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return hi[COORD_BITS-1:0];
        end else if (v < lo) begin
            return lo[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

    function automatic t_coord neg_sat(input t_coord v);
        logic signed [SAT_W-1:0] w;
        w = -SAT_W'(v);
        return sat_coord(w);
    endfunction

endpackage

>>> hdl/ball_wall_and_pair_collision.sv
// Ball wall and pair collision step, fully pipelined.
// Throughput: one transfer per cycle unless the output stalls;
// the square-root and divider stage chains set depth.
// A stalled output freezes the whole pipe; nothing is dropped or repeated.
// Reset (sync, active low) clears all valid bits; half extents return to 2.0.
module ball_wall_and_pair_collision
    import bwpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in                      i_in_data,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out                     o_out_data,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    // ---------------- registers ----------------
    logic [HALF_BITS-1:0] r_half_width;
    logic [HALF_BITS-1:0] r_half_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width  <= HALF_RESET;
            r_half_height <= HALF_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[CFG_ADDR_BITS-1])
                REG_HALF_WIDTH:  r_half_width  <= pwdata[HALF_BITS-1:0];
                REG_HALF_HEIGHT: r_half_height <= pwdata[HALF_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[CFG_ADDR_BITS-1])
            REG_HALF_WIDTH:  prdata = CFG_DATA_BITS'(r_half_width);
            REG_HALF_HEIGHT: prdata = CFG_DATA_BITS'(r_half_height);
        endcase
    end

    assign pready = 1'b1;

    // ---------------- pipe control ----------------
    // global advance: the output register is empty or being taken
    logic r_out_valid;
    logic en;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // ---------------- stage 1: advance/walls, differences ----------------
    t_coord wx, wvx, wy, wvy;
    logic   whx, why;

    bwpc_wall u_wall_x (
        .i_pos  (i_in_data.a_x),
        .i_vel  (i_in_data.a_vx),
        .i_rad  (i_in_data.a_radius),
        .i_half (r_half_width),
        .o_pos  (wx),
        .o_vel  (wvx),
        .o_hit  (whx)
    );

    bwpc_wall u_wall_y (
        .i_pos  (i_in_data.a_y),
        .i_vel  (i_in_data.a_vy),
        .i_rad  (i_in_data.a_radius),
        .i_half (r_half_height),
        .o_pos  (wy),
        .o_vel  (wvy),
        .o_hit  (why)
    );

    t_s1  r_s1, n_s1;
    logic r_v1;

    always_comb begin
        n_s1.side.op    = i_in_data.operation;
        n_s1.side.a_x   = i_in_data.a_x;
        n_s1.side.a_y   = i_in_data.a_y;
        n_s1.side.a_vx  = i_in_data.a_vx;
        n_s1.side.a_vy  = i_in_data.a_vy;
        n_s1.side.b_x   = i_in_data.b_x;
        n_s1.side.b_y   = i_in_data.b_y;
        n_s1.side.b_vx  = i_in_data.b_vx;
        n_s1.side.b_vy  = i_in_data.b_vy;
        n_s1.side.w_x   = wx;
        n_s1.side.w_y   = wy;
        n_s1.side.w_vx  = wvx;
        n_s1.side.w_vy  = wvy;
        n_s1.side.w_hit = whx || why;
        n_s1.side.dx    = D_W'(i_in_data.b_x) - D_W'(i_in_data.a_x);
        n_s1.side.dy    = D_W'(i_in_data.b_y) - D_W'(i_in_data.a_y);
        n_s1.dvx        = D_W'(i_in_data.b_vx) - D_W'(i_in_data.a_vx);
        n_s1.dvy        = D_W'(i_in_data.b_vy) - D_W'(i_in_data.a_vy);
        n_s1.rs         = RS_W'(i_in_data.a_radius) + RS_W'(i_in_data.b_radius);
    end

    // ---------------- stage 2: products ----------------
    t_s2               r_s2, n_s2;
    logic              r_v2;
    logic [RS_W-1:0]   rs1;
    logic signed [2*D_W-1:0] sqx, sqy;

    always_comb begin
        rs1           = r_s1.rs + RS_W'(1);
        sqx           = r_s1.side.dx * r_s1.side.dx;
        sqy           = r_s1.side.dy * r_s1.side.dy;
        n_s2.side     = r_s1.side;
        n_s2.dx2      = D2_W'(unsigned'(sqx));
        n_s2.dy2      = D2_W'(unsigned'(sqy));
        n_s2.px       = r_s1.side.dx * r_s1.dvx;
        n_s2.py       = r_s1.side.dy * r_s1.dvy;
        n_s2.rs2      = (2*RS_W)'(r_s1.rs) * (2*RS_W)'(r_s1.rs);
        n_s2.dxr      = DR_W'(r_s1.side.dx) * DR_W'(signed'({1'b0, rs1}));
        n_s2.dyr      = DR_W'(r_s1.side.dy) * DR_W'(signed'({1'b0, rs1}));
    end

    // ---------------- stage 3: distance, dot product, contact test ----------------
    t_sq  r_s3, n_s3;
    logic r_v3;

    always_comb begin
        n_s3.side  = r_s2.side;
        n_s3.d2    = r_s2.dx2 + r_s2.dy2;
        n_s3.p     = P_W'(r_s2.px) + P_W'(r_s2.py);
        // touching and not coincident
        n_s3.close = (n_s3.d2 != '0) && (n_s3.d2 <= D2_W'(r_s2.rs2));
        n_s3.dxr   = r_s2.dxr;
        n_s3.dyr   = r_s2.dyr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    // ---------------- |d| with GUARD extra fraction bits ----------------
    logic               sq_valid;
    logic [ROOT_W-1:0]  sq_root;
    logic [SQ_SB_W-1:0] sq_sb;
    t_sq                sq_out;

    bwpc_sqrt #(
        .IN_W (SQ_IN_W),
        .SB_W (SQ_SB_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v3),
        .i_n     ({r_s3.d2, {(2*GUARD){1'b0}}}),
        .i_sb    (r_s3),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_sb    (sq_sb)
    );

    assign sq_out = t_sq'(sq_sb);

    // ---------------- stage A: split products of d and p ----------------
    t_pa  r_pa, n_pa;
    logic r_va;
    logic signed [P_LO_W:0]   plo;
    logic signed [P_HI_W-1:0] phi;

    always_comb begin
        plo      = signed'({1'b0, sq_out.p[P_LO_W-1:0]});
        phi      = sq_out.p[P_W-1:P_LO_W];
        n_pa.sq  = sq_out;
        n_pa.len = sq_root;
        n_pa.lox = (D_W+P_LO_W+1)'(sq_out.side.dx) * (D_W+P_LO_W+1)'(plo);
        n_pa.loy = (D_W+P_LO_W+1)'(sq_out.side.dy) * (D_W+P_LO_W+1)'(plo);
        n_pa.hix = (D_W+P_HI_W)'(sq_out.side.dx) * (D_W+P_HI_W)'(phi);
        n_pa.hiy = (D_W+P_HI_W)'(sq_out.side.dy) * (D_W+P_HI_W)'(phi);
    end

    // ---------------- stage B: join partial products ----------------
    t_pb  r_pb, n_pb;
    logic r_vb;

    always_comb begin
        n_pb.sq   = r_pa.sq;
        n_pb.len  = r_pa.len;
        n_pb.numx = (NUMV_W'(r_pa.hix) <<< P_LO_W) + NUMV_W'(r_pa.lox);
        n_pb.numy = (NUMV_W'(r_pa.hiy) <<< P_LO_W) + NUMV_W'(r_pa.loy);
    end

    // ---------------- stage C: magnitudes with half-divisor rounding ----------------
    t_pc  r_pc, n_pc;
    logic r_vc;
    logic [NUMV_W-1:0] absx, absy;
    logic [DR_W-1:0]   abrx, abry;

    always_comb begin
        absx = r_pb.numx[NUMV_W-1] ? NUMV_W'(-r_pb.numx) : NUMV_W'(r_pb.numx);
        absy = r_pb.numy[NUMV_W-1] ? NUMV_W'(-r_pb.numy) : NUMV_W'(r_pb.numy);
        abrx = r_pb.sq.dxr[DR_W-1] ? DR_W'(-r_pb.sq.dxr) : DR_W'(r_pb.sq.dxr);
        abry = r_pb.sq.dyr[DR_W-1] ? DR_W'(-r_pb.sq.dyr) : DR_W'(r_pb.sq.dyr);
        n_pc.side  = r_pb.sq.side;
        n_pc.close = r_pb.sq.close;
        n_pc.d2    = r_pb.sq.d2;
        n_pc.len   = r_pb.len;
        n_pc.magvx = MAGV_W'(absx) + MAGV_W'(r_pb.sq.d2 >> 1);
        n_pc.magvy = MAGV_W'(absy) + MAGV_W'(r_pb.sq.d2 >> 1);
        n_pc.magpx = (MAGP_W'(abrx) << GUARD) + MAGP_W'(r_pb.len >> 1);
        n_pc.magpy = (MAGP_W'(abry) << GUARD) + MAGP_W'(r_pb.len >> 1);
        n_pc.negvx = r_pb.numx[NUMV_W-1];
        n_pc.negvy = r_pb.numy[NUMV_W-1];
        n_pc.negpx = r_pb.sq.dxr[DR_W-1];
        n_pc.negpy = r_pb.sq.dyr[DR_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (en) begin
            r_va <= sq_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
            r_pc <= n_pc;
        end
    end

    // ---------------- four dividers of equal depth ----------------
    // velocity change: d*p/|d|^2; placement: d*(rs+1)*2^GUARD/len
    t_fin                fin_in, fin_out;
    logic [FIN_SB_W-1:0] fin_sb;
    logic                dv_valid;
    logic [Q_W-1:0]      qvx, qvy, qpx, qpy;
    logic                nvy, npx, npy;

    assign fin_in.side  = r_pc.side;
    assign fin_in.close = r_pc.close;
    assign fin_in.neg   = r_pc.negvx;

    bwpc_div #(
        .NUM_W (MAGV_W),
        .DEN_W (D2_W),
        .Q_W   (Q_W),
        .SB_W  (FIN_SB_W)
    ) u_div_vx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vc),
        .i_num   (r_pc.magvx),
        .i_den   (r_pc.d2),
        .i_sb    (fin_in),
        .o_valid (dv_valid),
        .o_quo   (qvx),
        .o_sb    (fin_sb)
    );

    assign fin_out = t_fin'(fin_sb);

    // the other three run in lockstep; their valid copies are ANDed into the output valid
    logic vy_valid, px_valid, py_valid;

    bwpc_div #(
        .NUM_W (MAGV_W),
        .DEN_W (D2_W),
        .Q_W   (Q_W),
        .SB_W  (1)
    ) u_div_vy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vc),
        .i_num   (r_pc.magvy),
        .i_den   (r_pc.d2),
        .i_sb    (r_pc.negvy),
        .o_valid (vy_valid),
        .o_quo   (qvy),
        .o_sb    (nvy)
    );

    bwpc_div #(
        .NUM_W (MAGP_W),
        .DEN_W (ROOT_W),
        .Q_W   (Q_W),
        .SB_W  (1)
    ) u_div_px (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vc),
        .i_num   (r_pc.magpx),
        .i_den   (r_pc.len),
        .i_sb    (r_pc.negpx),
        .o_valid (px_valid),
        .o_quo   (qpx),
        .o_sb    (npx)
    );

    bwpc_div #(
        .NUM_W (MAGP_W),
        .DEN_W (ROOT_W),
        .Q_W   (Q_W),
        .SB_W  (1)
    ) u_div_py (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vc),
        .i_num   (r_pc.magpy),
        .i_den   (r_pc.len),
        .i_sb    (r_pc.negpy),
        .o_valid (py_valid),
        .o_quo   (qpy),
        .o_sb    (npy)
    );

    // ---------------- final stage: apply, saturate, select ----------------
    t_out r_out, n_out;
    logic signed [SAT_W-1:0] ddx, ddy, ofx, ofy;
    t_side sd;

    always_comb begin
        sd  = fin_out.side;
        ddx = fin_out.neg ? -SAT_W'({1'b0, qvx}) : SAT_W'({1'b0, qvx});
        ddy = nvy ? -SAT_W'({1'b0, qvy}) : SAT_W'({1'b0, qvy});
        ofx = npx ? -SAT_W'({1'b0, qpx}) : SAT_W'({1'b0, qpx});
        ofy = npy ? -SAT_W'({1'b0, qpy}) : SAT_W'({1'b0, qpy});

        // pass-through unless something happens
        n_out.new_a_x  = sd.a_x;
        n_out.new_a_y  = sd.a_y;
        n_out.new_a_vx = sd.a_vx;
        n_out.new_a_vy = sd.a_vy;
        n_out.new_b_x  = sd.b_x;
        n_out.new_b_y  = sd.b_y;
        n_out.new_b_vx = sd.b_vx;
        n_out.new_b_vy = sd.b_vy;
        n_out.hit      = 1'b0;
        if (sd.op == OP_ADVANCE) begin
            n_out.new_a_x  = sd.w_x;
            n_out.new_a_y  = sd.w_y;
            n_out.new_a_vx = sd.w_vx;
            n_out.new_a_vy = sd.w_vy;
            n_out.hit      = sd.w_hit;
        end else if (fin_out.close) begin
            n_out.new_a_vx = sat_coord(SAT_W'(sd.a_vx) + ddx);
            n_out.new_a_vy = sat_coord(SAT_W'(sd.a_vy) + ddy);
            n_out.new_b_vx = sat_coord(SAT_W'(sd.b_vx) - ddx);
            n_out.new_b_vy = sat_coord(SAT_W'(sd.b_vy) - ddy);
            n_out.new_b_x  = sat_coord(SAT_W'(sd.a_x) + ofx);
            n_out.new_b_y  = sat_coord(SAT_W'(sd.a_y) + ofy);
            n_out.hit      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid && vy_valid && px_valid && py_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hdl/bwpc_wall.sv
// One axis of the advance step: move, then clamp at the upper and lower wall.
// Depends on bwpc_pkg.
module bwpc_wall
    import bwpc_pkg::*;
(
    input  t_coord               i_pos,
    input  t_coord               i_vel,
    input  logic [RAD_BITS-1:0]  i_rad,
    input  logic [HALF_BITS-1:0] i_half,
    output t_coord               o_pos,
    output t_coord               o_vel,
    output logic                 o_hit
);

    logic signed [SAT_W-1:0] rad;
    logic signed [SAT_W-1:0] half;
    t_coord                  pos0;
    t_coord                  pos1;
    t_coord                  vel1;
    logic                    hit1;

    assign rad  = signed'(SAT_W'(i_rad));
    assign half = signed'(SAT_W'(i_half));

    always_comb begin
        pos0 = sat_coord(SAT_W'(i_pos) + SAT_W'(i_vel));
        pos1 = pos0;
        vel1 = i_vel;
        hit1 = 1'b0;
        if (SAT_W'(pos0) + rad > half) begin
            pos1 = COORD_BITS'(half - rad);
            vel1 = neg_sat(i_vel);
            hit1 = 1'b1;
        end
        o_pos = pos1;
        o_vel = vel1;
        o_hit = hit1;
        // oversized ball: the lower wall fires too and wins
        if (SAT_W'(pos1) - rad < -half) begin
            o_pos = COORD_BITS'(rad - half);
            o_vel = neg_sat(vel1);
            o_hit = 1'b1;
        end
    end

endmodule

>>> hdl/bwpc_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
// Depends on bwpc_pkg only through the widths handed in.
module bwpc_sqrt #(
    parameter int IN_W = 62,
    parameter int SB_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IN_W-1:0]   i_n,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_valid,
    output logic [IN_W/2-1:0] o_root,
    output logic [SB_W-1:0]   o_sb
);

    localparam int R_W = IN_W / 2;
    localparam int CW  = IN_W + 2;

    logic [IN_W-1:0] r_rem  [R_W];
    logic [R_W-1:0]  r_root [R_W];
    logic [SB_W-1:0] r_sb   [R_W];
    logic            r_vld  [R_W];
    logic [IN_W-1:0] n_rem  [R_W];
    logic [R_W-1:0]  n_root [R_W];

    always_comb begin
        logic [IN_W-1:0] rem_in;
        logic [R_W-1:0]  root_in;
        logic [CW-1:0]   inc;
        for (int k = 0; k < R_W; k++) begin
            if (k == 0) begin
                rem_in  = i_n;
                root_in = '0;
            end else begin
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
            end
            // (root + 2^b)^2 - root^2
            inc = (CW'(root_in) << (R_W - k)) + (CW'(1) << (2 * (R_W - 1 - k)));
            if (CW'(rem_in) >= inc) begin
                n_rem[k]  = IN_W'(CW'(rem_in) - inc);
                n_root[k] = root_in | (R_W'(1) << (R_W - 1 - k));
            end else begin
                n_rem[k]  = rem_in;
                n_root[k] = root_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < R_W; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < R_W; k++) r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < R_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_sb[k]   <= (k == 0) ? i_sb : r_sb[k-1];
            end
        end
    end

    assign o_valid = r_vld[R_W-1];
    assign o_root  = r_root[R_W-1];
    assign o_sb    = r_sb[R_W-1];

endmodule

>>> hdl/bwpc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Quotient is exact when i_num < i_den * 2^Q_W.
module bwpc_div #(
    parameter int NUM_W = 53,
    parameter int DEN_W = 34,
    parameter int Q_W   = 18,
    parameter int SB_W  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quo,
    output logic [SB_W-1:0]  o_sb
);

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [NUM_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];
    logic [SB_W-1:0]  r_sb  [Q_W];
    logic             r_vld [Q_W];
    logic [NUM_W-1:0] n_rem [Q_W];
    logic [Q_W-1:0]   n_q   [Q_W];

    always_comb begin
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   q_in;
        logic [CW-1:0]    trial;
        for (int k = 0; k < Q_W; k++) begin
            if (k == 0) begin
                rem_in = i_num;
                den_in = i_den;
                q_in   = '0;
            end else begin
                rem_in = r_rem[k-1];
                den_in = r_den[k-1];
                q_in   = r_q[k-1];
            end
            trial = CW'(den_in) << (Q_W - 1 - k);
            if (CW'(rem_in) >= trial) begin
                n_rem[k] = NUM_W'(CW'(rem_in) - trial);
                n_q[k]   = q_in | (Q_W'(1) << (Q_W - 1 - k));
            end else begin
                n_rem[k] = rem_in;
                n_q[k]   = q_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Q_W; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < Q_W; k++) r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Q_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_den[k] <= (k == 0) ? i_den : r_den[k-1];
                r_sb[k]  <= (k == 0) ? i_sb : r_sb[k-1];
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_q[Q_W-1];
    assign o_sb    = r_sb[Q_W-1];

endmodule

>>> hdl/bwpc_checker.sv
// Port-level checker for ball_wall_and_pair_collision, bound to the top level.
// Depends on bwpc_pkg and ball_wall_and_pair_collision_defines.svh.
`include "ball_wall_and_pair_collision_defines.svh"

module bwpc_checker
    import bwpc_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input t_in                      i_in_data,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input t_out                     o_out_data,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic [CFG_ADDR_BITS-1:0] paddr,
    input logic [CFG_DATA_BITS-1:0] pwdata,
    input logic [CFG_DATA_BITS-1:0] prdata,
    input logic                     pready
);

    // a held result stays put
    `BWPC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // input is taken exactly when the output slot frees up
    `BWPC_ASSERT_NOW(a_in_ready, 1'b1, o_in_ready == (!o_out_valid || i_out_ready))

    // nothing comes out right after reset
    `BWPC_ASSERT_NOW(a_rst_empty, !$past(i_rst_n), !o_out_valid)

    // a register write reads back at the same address
    `BWPC_ASSERT_NOW(a_cfg_rb, (psel && penable && pwrite && pready) ##1 (paddr == $past(paddr)), prdata[HALF_BITS-1:0] == $past(pwdata[HALF_BITS-1:0]))

endmodule

bind ball_wall_and_pair_collision bwpc_checker u_bwpc_checker (.*);

>>> test/tb_ball_wall_and_pair_collision.sv
// Testbench for ball_wall_and_pair_collision: directed and random ball steps checked
// against an in-bench fixed-point predictor. Depends on bwpc_pkg and the block's RTL.
module tb_ball_wall_and_pair_collision;
    import bwpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 64;     // pipe is 56 deep
    localparam int IN_BITS = $bits(t_in);

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    t_in                      i_in_data;
    logic                     o_out_valid;
    logic                     i_out_ready;
    t_out                     o_out_data;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    ball_wall_and_pair_collision dut (.*);

    // predictor copy of the box registers
    logic [HALF_BITS-1:0] box_half_w;
    logic [HALF_BITS-1:0] box_half_h;

    t_out expected_steps[$];
    int   mismatch_count;
    int   transfers_in;
    int   transfers_out;
    int   wall_hits;
    int   pair_hits;
    int   cfg_writes;

    // idling control shared by both sides, and a receiver hold-off
    bit   idle_on;
    int   long_hold;          // receiver hold-off request, in cycles

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor: 64-bit integer arithmetic, saturated back to 16 bits
    // ---------------------------------------------------------------
    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // round to nearest, ties away from zero; den always positive
    function automatic longint div_near(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // positive wall first, then negative; oversized balls hit both
    function automatic void wall_bounce(inout longint pos, inout longint vel,
                                        input longint rad, input longint half,
                                        inout logic h);
        if (pos + rad > half) begin
            pos = half - rad;
            vel = clamp16(-vel);
            h   = 1'b1;
        end
        if (pos - rad < -half) begin
            pos = -half + rad;
            vel = clamp16(-vel);
            h   = 1'b1;
        end
    endfunction

    function automatic t_out predict_step(t_in x);
        longint ax, ay, avx, avy, ar, bx, by, bvx, bvy, br;
        longint dx, dy, rs, p, ddx, ddy, reach, d2;
        longint unsigned len;
        logic h;
        t_out r;
        ax = x.a_x;   ay = x.a_y;   avx = x.a_vx; avy = x.a_vy;
        bx = x.b_x;   by = x.b_y;   bvx = x.b_vx; bvy = x.b_vy;
        ar = longint'(x.a_radius);
        br = longint'(x.b_radius);
        h  = 1'b0;
        if (x.operation == OP_ADVANCE) begin
            ax = clamp16(ax + avx);
            ay = clamp16(ay + avy);
            wall_bounce(ax, avx, ar, longint'(box_half_w), h);
            wall_bounce(ay, avy, ar, longint'(box_half_h), h);
        end else begin
            dx = bx - ax;
            dy = by - ay;
            d2 = dx * dx + dy * dy;
            rs = ar + br;
            // coincident centres and separated pairs pass through
            if (d2 != 0 && d2 <= rs * rs) begin
                p     = dx * (bvx - avx) + dy * (bvy - avy);
                ddx   = div_near(dx * p, d2);
                ddy   = div_near(dy * p, d2);
                len   = int_sqrt(longint'(unsigned'(d2)) << (2 * GUARD));
                reach = (rs + 1) * (longint'(1) << GUARD);
                h     = 1'b1;
                avx   = clamp16(avx + ddx);
                avy   = clamp16(avy + ddy);
                bvx   = clamp16(bvx - ddx);
                bvy   = clamp16(bvy - ddy);
                bx    = clamp16(ax + div_near(dx * reach, longint'(len)));
                by    = clamp16(ay + div_near(dy * reach, longint'(len)));
            end
        end
        r.new_a_x  = t_coord'(ax);
        r.new_a_y  = t_coord'(ay);
        r.new_a_vx = t_coord'(avx);
        r.new_a_vy = t_coord'(avy);
        r.new_b_x  = t_coord'(bx);
        r.new_b_y  = t_coord'(by);
        r.new_b_vx = t_coord'(bvx);
        r.new_b_vy = t_coord'(bvy);
        r.hit      = h;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Shared driver and register access
    // ---------------------------------------------------------------

    // one input transfer; expectation is queued at the accepting edge
    task automatic send_step(t_in x);
        t_out want;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        want = predict_step(x);
        expected_steps = {expected_steps, want};
        transfers_in++;
        if (want.hit) begin
            if (x.operation == OP_ADVANCE) wall_hits++;
            else pair_hits++;
        end
    endtask

    // drop valid, let every result come back, then cover the no-result tail
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_steps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_box(logic reg_sel, logic [CFG_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_HALF_WIDTH) box_half_w = value[HALF_BITS-1:0];
        else box_half_h = value[HALF_BITS-1:0];
        cfg_writes++;
    endtask

    task automatic set_box(int hw, int hh);
        wait_idle();
        // upper bits carry noise; the register keeps only its own width
        write_box(REG_HALF_WIDTH,  {17'($urandom_range(0, 131071)), HALF_BITS'(hw)});
        write_box(REG_HALF_HEIGHT, {17'($urandom_range(0, 131071)), HALF_BITS'(hh)});
    endtask

    // ---------------------------------------------------------------
    // Item builders
    // ---------------------------------------------------------------
    function automatic t_in make_item(logic op,
                                      int ax, int ay, int avx, int avy, int ar,
                                      int bx, int by, int bvx, int bvy, int br);
        t_in x;
        x.operation = op;
        x.a_x = t_coord'(ax);  x.a_y = t_coord'(ay);
        x.a_vx = t_coord'(avx); x.a_vy = t_coord'(avy);
        x.a_radius = RAD_BITS'(ar);
        x.b_x = t_coord'(bx);  x.b_y = t_coord'(by);
        x.b_vx = t_coord'(bvx); x.b_vy = t_coord'(bvy);
        x.b_radius = RAD_BITS'(br);
        return x;
    endfunction

    function automatic t_in noise_item();
        t_in x;
        x = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
        return x;
    endfunction

    function automatic int rnd_span(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // advance near the box, so walls are hit often
    function automatic t_in advance_item();
        int span, vmax, rmax;
        span = int'(box_half_w > box_half_h ? box_half_w : box_half_h) + 2000;
        vmax = ($urandom_range(0, 7) == 0) ? 32767 : 3000;
        rmax = ($urandom_range(0, 7) == 0) ? 16383 : 4000;
        return make_item(OP_ADVANCE,
                         rnd_span(-span, span), rnd_span(-span, span),
                         rnd_span(-vmax, vmax), rnd_span(-vmax, vmax),
                         $urandom_range(0, rmax),
                         rnd_span(-32768, 32767), rnd_span(-32768, 32767),
                         rnd_span(-32768, 32767), rnd_span(-32768, 32767),
                         $urandom_range(0, 16383));
    endfunction

    // pair whose centre offset lies within the radius sum box: mostly touching
    function automatic t_in touching_pair();
        int ar, br, rs, dx, dy, ax, ay, vmax;
        ar = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 4000);
        br = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 4000);
        rs = ar + br;
        dx = rnd_span(-rs, rs);
        dy = rnd_span(-rs, rs);
        ax = rnd_span(-20000, 20000);
        ay = rnd_span(-20000, 20000);
        vmax = ($urandom_range(0, 7) == 0) ? 32767 : 4000;
        return make_item(OP_PAIR, ax, ay, rnd_span(-vmax, vmax), rnd_span(-vmax, vmax), ar,
                         int'(clamp16(ax + dx)), int'(clamp16(ay + dy)),
                         rnd_span(-vmax, vmax), rnd_span(-vmax, vmax), br);
    endfunction

    function automatic t_in mixed_item();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return touching_pair();
        if (pick < 8) return advance_item();
        return noise_item();
    endfunction

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ---------------------------------------------------------------
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (long_hold > 0) begin
            i_out_ready <= 1'b0;
            long_hold   <= long_hold - 1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 4);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Result checker: every output transfer against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            transfers_out++;
            if (expected_steps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result %h", $realtime, o_out_data);
            end else begin
                want = expected_steps.pop_front();
                if (o_out_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("[%0t] mismatch on result %0d", $realtime, transfers_out);
                        $display("  A pos exp %0d,%0d got %0d,%0d", want.new_a_x,
                                 want.new_a_y, o_out_data.new_a_x, o_out_data.new_a_y);
                        $display("  A vel exp %0d,%0d got %0d,%0d", want.new_a_vx,
                                 want.new_a_vy, o_out_data.new_a_vx, o_out_data.new_a_vy);
                        $display("  B pos exp %0d,%0d got %0d,%0d", want.new_b_x,
                                 want.new_b_y, o_out_data.new_b_x, o_out_data.new_b_y);
                        $display("  B vel exp %0d,%0d got %0d,%0d", want.new_b_vx,
                                 want.new_b_vy, o_out_data.new_b_vx, o_out_data.new_b_vy);
                        $display("  hit   exp %0b got %0b", want.hit, o_out_data.hit);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // walls, oversized ball, saturated advance, negation of the most negative speed
    task automatic test_advance_directed();
        send_step(make_item(OP_ADVANCE, 0, 0, 0, 0, 0, 1, 2, 3, 4, 5));
        send_step(make_item(OP_ADVANCE, 15000, 0, 2000, 0, 1000, -1, -1, -1, -1, 16383));
        send_step(make_item(OP_ADVANCE, -15000, 0, -2000, 0, 1000, 0, 0, 0, 0, 0));
        send_step(make_item(OP_ADVANCE, 0, 15000, 0, 2000, 1000, 0, 0, 0, 0, 0));
        send_step(make_item(OP_ADVANCE, 0, -15000, 0, -2000, 1000, 0, 0, 0, 0, 0));
        send_step(make_item(OP_ADVANCE, 15000, 15000, 3000, 3000, 2000, 0, 0, 0, 0, 0));
        send_step(make_item(OP_ADVANCE, 0, 0, 100, -100, 16383, 0, 0, 0, 0, 0));
        send_step(make_item(OP_ADVANCE, 32767, -32768, 32767, -32768, 0,
                            32767, -32768, 32767, -32768, 0));
        send_step(make_item(OP_ADVANCE, 0, 0, -32768, -32768, 0, 0, 0, 0, 0, 0));
        send_step(make_item(OP_ADVANCE, -32768, 32767, -32768, 32767, 16383,
                            -32768, 32767, -32768, 32767, 16383));
    endtask

    // apart, coincident, head-on, separating, extremes of radius and speed
    task automatic test_pair_directed();
        send_step(make_item(OP_PAIR, 0, 0, 100, 0, 1000, 5000, 0, -100, 0, 1000));
        send_step(make_item(OP_PAIR, 300, -200, 100, 50, 1000, 300, -200, -100, 7, 1000));
        send_step(make_item(OP_PAIR, 0, 0, 500, 0, 1000, 1500, 0, -500, 0, 1000));
        send_step(make_item(OP_PAIR, 0, 0, -500, 0, 1000, 1500, 0, 500, 0, 1000));
        send_step(make_item(OP_PAIR, 0, 0, 300, 200, 1000, 1200, 900, -300, -100, 600));
        send_step(make_item(OP_PAIR, -32768, -32768, 32767, 32767, 16383,
                            32767, 32767, -32768, -32768, 16383));
        send_step(make_item(OP_PAIR, -32768, 0, -32768, 32767, 16383,
                            -10000, 0, 32767, -32768, 16383));
        send_step(make_item(OP_PAIR, 30000, 30000, 1000, 1000, 8000,
                            32767, 32767, -1000, -1000, 8000));
        send_step(make_item(OP_PAIR, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        send_step(make_item(OP_PAIR, 0, 0, 0, 0, 1, 1, 1, 0, 0, 1));
        send_step(make_item(OP_PAIR, 0, 0, 7, -9, 16383, 0, 1, -7, 9, 0));
    endtask

    // advance steps at box extremes, then mixed steps at a random box size
    task automatic test_box_sizes();
        int hw[4] = '{0, 32767, 32767, 0};
        int hh[4] = '{32767, 0, 32767, 0};
        foreach (hw[k]) begin
            set_box(hw[k], hh[k]);
            repeat (40) send_step(advance_item());
        end
        set_box($urandom_range(1, 32766), $urandom_range(1, 32766));
        repeat (60) send_step(mixed_item());
    endtask

    task automatic test_random_mix(int count);
        repeat (count) send_step(mixed_item());
    endtask

    // receiver holds off so the pipe fills and the input stalls
    task automatic test_backpressure();
        long_hold = 300;
        repeat (150) send_step(mixed_item());
    endtask

    // back-to-back transfers with no idling on either side
    task automatic test_full_rate();
        set_box(16384, 16384);
        idle_on = 1'b0;
        repeat (250) send_step(mixed_item());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        box_half_w  = HALF_RESET;
        box_half_h  = HALF_RESET;
        idle_on     = 1'b1;
        long_hold   = 0;
        mismatch_count = 0;
        transfers_in   = 0;
        transfers_out  = 0;
        wall_hits      = 0;
        pair_hits      = 0;
        cfg_writes     = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_advance_directed();
        test_pair_directed();
        test_box_sizes();
        set_box($urandom_range(8192, 24576), $urandom_range(8192, 24576));
        test_random_mix(660);
        test_backpressure();
        test_full_rate();

        wait_idle();
        if (expected_steps.size() != 0) mismatch_count++;
        $display("Covered %0d transfers in, %0d out, %0d box writes.",
                 transfers_in, transfers_out, cfg_writes);
        $display("Saw %0d wall bounces and %0d pair collisions; mismatches: %0d",
                 wall_hits, pair_hits, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
